FILE: hw/rtl/pclru_pkg.sv
// ----------------------------------------------------------------------------
// pclru_pkg
// Shared widths, op codes and controller/datapath interface types for the
// page cache LRU lookup block.
// ----------------------------------------------------------------------------
package pclru_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned PAGE_W  = 32;
  localparam int unsigned OWNER_W = 16;
  localparam int unsigned SLOT_W  = 4;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  typedef struct packed {
    logic load_req;
    logic do_match;
    logic do_commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_status_t;

endpackage

FILE: hw/rtl/pclru_ctrl.sv
// ----------------------------------------------------------------------------
// pclru_ctrl
// Request sequencer: capture, associative match, commit of the LRU update.
// ----------------------------------------------------------------------------
module pclru_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  out_tready,
  input  pclru_pkg::dp_status_t status,
  output pclru_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_free;
  logic   commit;

  assign out_free  = !status.out_valid || out_tready;
  assign commit    = (state_r == S_UPDATE) && out_free;
  assign in_tready = (state_r == S_IDLE) || commit;

  assign cmd.load_req  = in_tvalid && in_tready;
  assign cmd.do_match  = (state_r == S_MATCH);
  assign cmd.do_commit = commit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) state_nxt = in_tvalid ? S_MATCH : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_match_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MATCH |=> state_r == S_UPDATE)
    else $error("match stage not followed by update");

endmodule

FILE: hw/rtl/pclru_datapath.sv
// ----------------------------------------------------------------------------
// pclru_datapath
// Entry store with per-entry key compare, recency ranks, victim and free
// slot selection, and the result register.
// ----------------------------------------------------------------------------
module pclru_datapath #(
  parameter int unsigned CAPACITY = pclru_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pclru_pkg::dp_cmd_t            cmd,
  output pclru_pkg::dp_status_t         status,
  input  logic                          in_op,
  input  logic [pclru_pkg::PAGE_W-1:0]  in_page,
  input  logic [pclru_pkg::OWNER_W-1:0] in_owner,
  input  logic                          in_dirty,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic                          out_hit,
  output logic [pclru_pkg::SLOT_W-1:0]  out_slot,
  output logic                          out_evicted,
  output logic [pclru_pkg::PAGE_W-1:0]  out_evicted_page,
  output logic [pclru_pkg::OWNER_W-1:0] out_evicted_owner,
  output logic                          out_dirty_evict
);

  localparam int unsigned RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OCC_W  = $clog2(CAPACITY + 1);

  // request
  logic                          req_op_r;
  logic [pclru_pkg::PAGE_W-1:0]  req_page_r;
  logic [pclru_pkg::OWNER_W-1:0] req_owner_r;
  logic                          req_dirty_r;

  // entries
  logic [CAPACITY-1:0]           valid_r;
  logic [pclru_pkg::PAGE_W-1:0]  page_r  [CAPACITY];
  logic [pclru_pkg::OWNER_W-1:0] owner_r [CAPACITY];
  logic                          dirty_r [CAPACITY];
  logic [RANK_W-1:0]             rank_r  [CAPACITY];
  logic [OCC_W-1:0]              occ_r;

  // match stage
  logic [CAPACITY-1:0] match_c,    match_r;
  logic [CAPACITY-1:0] rank_hit_c, rank_hit_r;
  logic [CAPACITY-1:0] evict_c,    evict_r;
  logic [CAPACITY-1:0] free_c,     free_r;
  logic                full_c,     full_r;

  // update stage
  logic [CAPACITY-1:0]           min_oh;
  logic [RANK_W-1:0]             best_rank;
  logic [CAPACITY-1:0]           best_vec;
  logic                          found;
  logic                          is_add;
  logic                          do_evict;
  logic [CAPACITY-1:0]           tgt_vec;
  logic [RANK_W-1:0]             tgt_idx;
  logic [pclru_pkg::PAGE_W-1:0]  ev_page;
  logic [pclru_pkg::OWNER_W-1:0] ev_owner;
  logic                          ev_dirty;

  // result register
  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [pclru_pkg::SLOT_W-1:0]  out_slot_r;
  logic                          out_evicted_r;
  logic [pclru_pkg::PAGE_W-1:0]  out_page_r;
  logic [pclru_pkg::OWNER_W-1:0] out_owner_r;
  logic                          out_wb_r;

  always_comb begin
    match_c    = '0;
    rank_hit_c = '0;
    evict_c    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_c[i] = valid_r[i] && (page_r[i] == req_page_r) && (owner_r[i] == req_owner_r);
      evict_c[i] = valid_r[i] && (rank_r[i] == RANK_W'(CAPACITY - 1));
      for (int r = 0; r < CAPACITY; r++) begin
        if (match_c[i] && (rank_r[i] == RANK_W'(r))) rank_hit_c[r] = 1'b1;
      end
    end
    free_c = ~valid_r & (valid_r + 1'b1);
    full_c = (occ_r == OCC_W'(CAPACITY));
  end

  always_comb begin
    min_oh    = rank_hit_r & (~rank_hit_r + 1'b1);
    best_rank = '0;
    for (int r = 0; r < CAPACITY; r++) begin
      if (min_oh[r]) best_rank = best_rank | RANK_W'(r);
    end
    best_vec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      best_vec[i] = match_r[i] && (rank_r[i] == best_rank);
    end
    found    = |match_r;
    is_add   = (req_op_r == pclru_pkg::OP_ADD);
    do_evict = is_add && full_r;
    if (is_add) begin
      tgt_vec = full_r ? evict_r : free_r;
    end else begin
      tgt_vec = best_vec;
    end
    tgt_idx  = '0;
    ev_page  = '0;
    ev_owner = '0;
    ev_dirty = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tgt_vec[i]) tgt_idx = tgt_idx | RANK_W'(i);
      if (evict_r[i]) begin
        ev_page  = ev_page | page_r[i];
        ev_owner = ev_owner | owner_r[i];
        ev_dirty = ev_dirty | dirty_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r    <= in_op;
      req_page_r  <= in_page;
      req_owner_r <= in_owner;
      req_dirty_r <= in_dirty;
    end
    if (cmd.do_match) begin
      match_r    <= match_c;
      rank_hit_r <= rank_hit_c;
      evict_r    <= evict_c;
      free_r     <= free_c;
      full_r     <= full_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_commit) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (is_add) begin
          if (tgt_vec[i]) begin
            page_r[i]  <= req_page_r;
            owner_r[i] <= req_owner_r;
            dirty_r[i] <= req_dirty_r;
            rank_r[i]  <= '0;
          end else if (valid_r[i]) begin
            rank_r[i] <= RANK_W'(rank_r[i] + 1'b1);
          end
        end else if (found) begin
          if (best_vec[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < best_rank)) begin
            rank_r[i] <= RANK_W'(rank_r[i] + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (cmd.do_commit && is_add) begin
      valid_r <= valid_r | tgt_vec;
      if (!full_r) occ_r <= OCC_W'(occ_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_commit) begin
      out_hit_r     <= !is_add && found;
      out_slot_r    <= pclru_pkg::SLOT_W'(tgt_idx);
      out_evicted_r <= do_evict;
      out_page_r    <= do_evict ? ev_page : '0;
      out_owner_r   <= do_evict ? ev_owner : '0;
      out_wb_r      <= do_evict && ev_dirty;
    end
  end

  assign status.out_valid  = out_valid_r;
  assign out_tvalid        = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted       = out_evicted_r;
  assign out_evicted_page  = out_page_r;
  assign out_evicted_owner = out_owner_r;
  assign out_dirty_evict   = out_wb_r;

  a_occ_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == OCC_W'($countones(valid_r)))
    else $error("occupancy differs from valid entry count");

  a_single_victim: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_commit && is_add && full_r |-> $onehot(evict_r))
    else $error("eviction without a unique least recent entry");

  a_single_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_commit && !is_add && found |-> $onehot(best_vec))
    else $error("lookup hit without a unique most recent match");

  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_commit && is_add && !full_r |-> $onehot(free_r))
    else $error("add below capacity without a free slot");

endmodule

FILE: hw/rtl/page_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// page_cache_lru_lookup
// Fully associative page cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each item is matched, then committed: the match state registers the key
// compare against every entry together with the victim and free-slot picks;
// the update state commits the rank update and loads the result register.
// The next beat is accepted on the commit edge, so a new request waits for
// the last to commit; a result that is not taken stalls the commit until the
// result register frees. Lookups return the most recent matching entry; adds
// evict the least recent entry once all CAPACITY slots are full.
module page_cache_lru_lookup #(
  parameter int unsigned CAPACITY = pclru_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] page_number, [47:32] owner_id, [48] dirty_in, [55:49] zero
  input  logic [pclru_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] op
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] hit, [4:1] slot, [5] evicted, [37:6] evicted_page,
  // [53:38] evicted_owner, [54] dirty_evict, [55] zero
  output logic [pclru_pkg::OUT_TDATA_W-1:0] out_tdata
);

  pclru_pkg::dp_cmd_t    cmd;
  pclru_pkg::dp_status_t status;

  logic                          o_hit;
  logic [pclru_pkg::SLOT_W-1:0]  o_slot;
  logic                          o_evicted;
  logic [pclru_pkg::PAGE_W-1:0]  o_page;
  logic [pclru_pkg::OWNER_W-1:0] o_owner;
  logic                          o_wb;

  pclru_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  pclru_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_op             (in_tuser),
    .in_page           (in_tdata[31:0]),
    .in_owner          (in_tdata[47:32]),
    .in_dirty          (in_tdata[48]),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_hit           (o_hit),
    .out_slot          (o_slot),
    .out_evicted       (o_evicted),
    .out_evicted_page  (o_page),
    .out_evicted_owner (o_owner),
    .out_dirty_evict   (o_wb)
  );

  assign out_tdata = {1'b0, o_wb, o_owner, o_page, o_evicted, o_slot, o_hit};

endmodule
